// File: design/ctf_pkg.sv
package ctf_pkg;

  // Angle unit: 1/25600 degree
  localparam int AngW = 26;
  localparam logic signed [AngW-1:0] Deg180 = 26'sd4608000;
  localparam logic signed [AngW-1:0] Deg90  = 26'sd2304000;
  localparam int AtanLen = 24;
  localparam logic [31:0] RateScaleQ32 = 32'd6152087;

  // Configuration register indexes
  localparam logic [0:0] RegWeight = 1'b0;
  localparam logic [0:0] RegPeriod = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQRT,
    ST_PREP,
    ST_CORDIC,
    ST_MUL1,
    ST_MUL2,
    ST_BLEND1,
    ST_BLEND2,
    ST_NEXT,
    ST_OUT
  } state_e;

  // arctan(2^-i) table, 1/25600 degree
  function automatic logic [20:0] atan_lut(input logic [4:0] i);
    logic [20:0] r;
    case (i)
      5'd0:  r = 21'd1152000;
      5'd1:  r = 21'd680065;
      5'd2:  r = 21'd359328;
      5'd3:  r = 21'd182400;
      5'd4:  r = 21'd91554;
      5'd5:  r = 21'd45822;
      5'd6:  r = 21'd22916;
      5'd7:  r = 21'd11459;
      5'd8:  r = 21'd5730;
      5'd9:  r = 21'd2865;
      5'd10: r = 21'd1432;
      5'd11: r = 21'd716;
      5'd12: r = 21'd358;
      5'd13: r = 21'd179;
      5'd14: r = 21'd90;
      5'd15: r = 21'd45;
      5'd16: r = 21'd22;
      5'd17: r = 21'd11;
      5'd18: r = 21'd6;
      5'd19: r = 21'd3;
      5'd20: r = 21'd1;
      5'd21: r = 21'd1;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/complementary_tilt_filter_unit.sv
// Channel   Direction  Payload
// s_axis    in         tdata: accel_x, accel_y, accel_z, gyro_x, gyro_y (80 bits)
// m_axis    out        tdata: roll_angle, pitch_angle (31 bits, 32 wide); tuser: first_sample
// cfg       in         cfg_index_i (0 weight, 1 period), cfg_data_i
//
// Each item runs through the squaring states ST_SQ_Y and ST_SQ_Z and the square root state
// ST_SQRT, then per axis the setup state ST_PREP, one CORDIC add/shift step per configured
// step (CORDIC_STEPS, capped at 24) and the multiply/blend states ST_MUL1 to ST_NEXT, then
// the output state ST_OUT and back to idle.
// s_axis_tready is high only in idle with the output register empty or taken.
// Reset clears the estimates, the primed flag and loads the default registers.
module complementary_tilt_filter_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_x[63:48], gyro_y[79:64]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // roll_angle[15:0], pitch_angle[30:16], zero[31]
  output logic [31:0] m_axis_tdata,
  // first_sample[0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int Steps = (CORDIC_STEPS > ctf_pkg::AtanLen) ? ctf_pkg::AtanLen : CORDIC_STEPS;
  localparam logic [4:0] LastStep = 5'(Steps - 1);
  localparam logic [4:0] SqrtLast = 5'd23;
  localparam int CW = 28; // CORDIC x/y width
  localparam int AW = ctf_pkg::AngW;

  // Clamp an angle to +/-lim_v
  function automatic logic signed [AW-1:0] ang_sat(input logic signed [AW-1:0] z,
                                                   input logic signed [AW-1:0] lim_v);
    logic signed [AW-1:0] r;
    r = z;
    if (z > lim_v) r = lim_v;
    else if (z < -lim_v) r = -lim_v;
    return r;
  endfunction

  ctf_pkg::state_e state_q, state_d;

  logic [15:0] weight_q, period_q;
  logic signed [23:0] roll_q, pitch_q;
  logic primed_q;

  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;

  // square root state
  logic [47:0] rad_q;
  logic [25:0] rem_q;
  logic [23:0] root_q;
  logic [4:0]  cnt_q;

  // CORDIC state
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [AW-1:0] cz_q;
  logic zero_vec_q;
  logic axis_q; // 0 roll, 1 pitch
  logic signed [AW-1:0] acc_roll_q, acc_pitch_q;

  // multiplier path
  logic signed [31:0] prod_q;
  logic signed [AW-1:0] inc_q;
  logic signed [47:0] bsum_q;

  logic        out_valid_q;
  logic [15:0] out_roll_q;
  logic [14:0] out_pitch_q;
  logic        out_first_q;

  logic accept;
  assign s_axis_tready = (state_q == ctf_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = (state_q == ctf_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ctf_pkg::ST_IDLE:   if (accept) state_d = ctf_pkg::ST_SQ_Y;
      ctf_pkg::ST_SQ_Y:   state_d = ctf_pkg::ST_SQ_Z;
      ctf_pkg::ST_SQ_Z:   state_d = ctf_pkg::ST_SQRT;
      ctf_pkg::ST_SQRT:   if (cnt_q == SqrtLast) state_d = ctf_pkg::ST_PREP;
      ctf_pkg::ST_PREP:   state_d = ctf_pkg::ST_CORDIC;
      ctf_pkg::ST_CORDIC: if (cnt_q == LastStep) state_d = ctf_pkg::ST_MUL1;
      ctf_pkg::ST_MUL1:   state_d = ctf_pkg::ST_MUL2;
      ctf_pkg::ST_MUL2:   state_d = ctf_pkg::ST_BLEND1;
      ctf_pkg::ST_BLEND1: state_d = ctf_pkg::ST_BLEND2;
      ctf_pkg::ST_BLEND2: state_d = ctf_pkg::ST_NEXT;
      ctf_pkg::ST_NEXT:   state_d = axis_q ? ctf_pkg::ST_OUT : ctf_pkg::ST_PREP;
      ctf_pkg::ST_OUT:    state_d = ctf_pkg::ST_IDLE;
      default:            state_d = ctf_pkg::ST_IDLE;
    endcase
  end

  // Shared datapath signals
  logic [27:0] trial;
  logic [27:0] rem_sh;
  logic signed [CW-1:0] cx_sh, cy_sh, px, py, pxa, pya;
  logic signed [AW-1:0] pz, tbl, acc_sel, lim;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [AW-1:0] est_sel, blend_sat;
  logic signed [47:0] bsum_next;
  logic [15:0] g_sel;
  logic signed [AW-1:0] out_rnd_r, out_rnd_p;

  always_comb begin
    // root: one result bit per cycle, 24 bits of root over a 48-bit radicand
    rem_sh = {rem_q, rad_q[47:46]};
    trial  = {2'b00, root_q, 2'b01};
    // CORDIC step
    cx_sh = cx_q >>> cnt_q;
    cy_sh = cy_q >>> cnt_q;
    tbl   = AW'($signed({1'b0, ctf_pkg::atan_lut(cnt_q)}));
    // pre-rotation of the axis operands
    if (!axis_q) begin
      py = CW'($signed(ay_q)) <<< 8;
      px = CW'($signed(az_q)) <<< 8;
    end else begin
      py = CW'($signed(ax_q)) <<< 8;
      px = CW'($signed({1'b0, root_q}));
    end
    pz  = '0;
    pxa = px;
    pya = py;
    if (px < 0) begin
      pz  = (py >= 0) ? ctf_pkg::Deg180 : -ctf_pkg::Deg180;
      pxa = -px;
      pya = -py;
    end
    lim     = axis_q ? ctf_pkg::Deg90 : ctf_pkg::Deg180;
    acc_sel = axis_q ? acc_pitch_q : acc_roll_q;
    est_sel = axis_q ? AW'(pitch_q) : AW'(roll_q);
    g_sel   = axis_q ? gy_q : gx_q;
    // one multiplier, shared by all products
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ctf_pkg::ST_SQ_Y:   begin
        mul_a = 32'($signed(ay_q));
        mul_b = 32'($signed(ay_q));
      end
      ctf_pkg::ST_SQ_Z:   begin
        mul_a = 32'($signed(az_q));
        mul_b = 32'($signed(az_q));
      end
      ctf_pkg::ST_MUL1:   begin
        mul_a = 32'($signed(g_sel));
        mul_b = 32'($signed({1'b0, period_q}));
      end
      ctf_pkg::ST_MUL2:   begin
        mul_a = prod_q;
        mul_b = $signed(ctf_pkg::RateScaleQ32);
      end
      ctf_pkg::ST_BLEND1: begin
        mul_a = 32'(est_sel + inc_q);
        mul_b = 32'($signed({1'b0, weight_q}));
      end
      ctf_pkg::ST_BLEND2: begin
        mul_a = 32'(acc_sel);
        mul_b = 32'($signed({1'b0, 17'h10000 - {1'b0, weight_q}}));
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
    bsum_next = bsum_q + mul_p[47:0];
    blend_sat = AW'(bsum_q >>> 16);
    if ((bsum_q >>> 16) > 48'(lim)) blend_sat = lim;
    else if ((bsum_q >>> 16) < -48'(lim)) blend_sat = -lim;
    out_rnd_r = (AW'(roll_q) + 26'sd128) >>> 8;
    out_rnd_p = (AW'(pitch_q) + 26'sd128) >>> 8;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctf_pkg::ST_IDLE;
      weight_q    <= 16'd58982;
      period_q    <= 16'd10000;
      roll_q      <= '0;
      pitch_q     <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      axis_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == ctf_pkg::RegWeight) weight_q <= cfg_data_i;
        else if (cfg_index_i == ctf_pkg::RegPeriod) period_q <= cfg_data_i;
      end
      // raise on output, drop when the item is taken
      if (state_q == ctf_pkg::ST_OUT) out_valid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        ctf_pkg::ST_IDLE: begin
          cnt_q  <= '0;
          axis_q <= 1'b0;
        end
        ctf_pkg::ST_SQRT: cnt_q <= (cnt_q == SqrtLast) ? 5'd0 : cnt_q + 5'd1;
        ctf_pkg::ST_PREP: cnt_q <= '0;
        ctf_pkg::ST_CORDIC: cnt_q <= cnt_q + 5'd1;
        ctf_pkg::ST_BLEND2: begin
          // store estimate for this axis
          if (!primed_q) begin
            if (axis_q) pitch_q <= 24'(acc_sel);
            else        roll_q  <= 24'(acc_sel);
          end
        end
        ctf_pkg::ST_NEXT: axis_q <= 1'b1;
        ctf_pkg::ST_OUT: primed_q <= 1'b1;
        default: ;
      endcase
      if (state_q == ctf_pkg::ST_NEXT && primed_q) begin
        if (axis_q) pitch_q <= 24'(blend_sat);
        else        roll_q  <= 24'(blend_sat);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q   <= s_axis_tdata[15:0];
      ay_q   <= s_axis_tdata[31:16];
      az_q   <= s_axis_tdata[47:32];
      gx_q   <= s_axis_tdata[63:48];
      gy_q   <= s_axis_tdata[79:64];
      rem_q  <= '0;
      root_q <= '0;
    end
    case (state_q)
      // radicand (ay^2+az^2) << 16
      ctf_pkg::ST_SQ_Y: rad_q <= {mul_p[31:0], 16'h0000};
      ctf_pkg::ST_SQ_Z: rad_q <= {rad_q[47:16] + mul_p[31:0], 16'h0000};
      ctf_pkg::ST_SQRT: begin
        // two radicand bits per cycle, MSB first
        if (rem_sh >= trial) begin
          rem_q  <= 26'(rem_sh - trial);
          root_q <= {root_q[22:0], 1'b1};
        end else begin
          rem_q  <= rem_sh[25:0];
          root_q <= {root_q[22:0], 1'b0};
        end
        rad_q <= {rad_q[45:0], 2'b00};
      end
      ctf_pkg::ST_PREP: begin
        cx_q       <= pxa;
        cy_q       <= pya;
        cz_q       <= pz;
        zero_vec_q <= (px == '0) && (py == '0);
      end
      ctf_pkg::ST_CORDIC: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + cy_sh;
          cy_q <= cy_q - cx_sh;
          cz_q <= cz_q + tbl;
        end else begin
          cx_q <= cx_q - cy_sh;
          cy_q <= cy_q + cx_sh;
          cz_q <= cz_q - tbl;
        end
      end
      ctf_pkg::ST_MUL1: begin
        // a zero vector has angle zero
        if (!axis_q) acc_roll_q <= zero_vec_q ? '0 : ang_sat(cz_q, ctf_pkg::Deg180);
        else         acc_pitch_q <= zero_vec_q ? '0 : ang_sat(cz_q, ctf_pkg::Deg90);
        prod_q <= mul_p[31:0];
      end
      ctf_pkg::ST_MUL2: begin
        inc_q  <= AW'((mul_p + 64'sh80000000) >>> 32);
        bsum_q <= 48'sd32768;
      end
      ctf_pkg::ST_BLEND1: bsum_q <= bsum_next;
      ctf_pkg::ST_BLEND2: bsum_q <= bsum_next;
      ctf_pkg::ST_OUT: begin
        out_roll_q  <= out_rnd_r[15:0];
        out_pitch_q <= out_rnd_p[14:0];
        out_first_q <= !primed_q;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_pitch_q, out_roll_q};
  assign m_axis_tuser  = out_first_q;

  // Hold a waiting result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser));

  // Input is taken only in idle, and not again on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready);

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd18000) &&
                      ($signed(m_axis_tdata[15:0]) >= -16'sd18000));

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[30:16]) <= 15'sd9000) &&
                      ($signed(m_axis_tdata[30:16]) >= -15'sd9000));

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31] == 1'b0));

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CordicSteps = 16;
  localparam int Deg180V = 4608000;
  localparam int Deg90V = 2304000;
  localparam longint RateScale = 6152087;
  localparam int IdxWeight = int'(ctf_pkg::RegWeight);
  localparam int IdxPeriod = int'(ctf_pkg::RegPeriod);

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic first;
  } tilt_t;

  // arctan(2^-i) in 1/25600 degree
  localparam int AtanTab[24] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
    11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0};

  // Expected-angle tracker: own copy of the filter state and registers
  class tilt_scoreboard;
    longint weight, period_us, roll_est, pitch_est;
    bit primed;
    tilt_t pending[$];
    int mismatches, checked;

    function void reset_state();
      weight = 58982; period_us = 10000;
      roll_est = 0; pitch_est = 0; primed = 0;
    endfunction

    function void write_reg(int idx, logic [15:0] val);
      if (idx == IdxWeight) weight = val;
      else if (idx == IdxPeriod) period_us = val;
    endfunction

    function longint asr(longint v, int s);
      return v >>> s;
    endfunction

    function longint isqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b; res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return longint'(res);
    endfunction

    function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint vec_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? Deg180V : -Deg180V;
        x = -x; y = -y;
      end
      for (int i = 0; i < CordicSteps && i < 24; i++) begin
        dx = asr(y, i); dy = asr(x, i);
        if (y > 0) begin
          x += dx; y -= dy; z += AtanTab[i];
        end else begin
          x -= dx; y += dy; z -= AtanTab[i];
        end
      end
      return z;
    endfunction

    function longint rate_step(longint g);
      return asr(g * period_us * RateScale + (64'sd1 <<< 31), 32);
    endfunction

    function longint mix(longint est, longint inc, longint accel);
      return asr(weight * (est + inc) + (65536 - weight) * accel + 32768, 16);
    endfunction

    function void note_sample(logic [79:0] d);
      longint ax, ay, az, gx, gy, mag, acc_r, acc_p;
      tilt_t e;
      ax = longint'($signed(d[15:0])); ay = longint'($signed(d[31:16]));
      az = longint'($signed(d[47:32])); gx = longint'($signed(d[63:48]));
      gy = longint'($signed(d[79:64]));
      mag = isqrt((ay * ay + az * az) << 16);
      acc_r = clip(vec_angle(ay * 256, az * 256), Deg180V);
      acc_p = clip(vec_angle(ax * 256, mag), Deg90V);
      if (!primed) begin
        roll_est = acc_r; pitch_est = acc_p; primed = 1; e.first = 1;
      end else begin
        roll_est = clip(mix(roll_est, rate_step(gx), acc_r), Deg180V);
        pitch_est = clip(mix(pitch_est, rate_step(gy), acc_p), Deg90V);
        e.first = 0;
      end
      e.roll = 16'(asr(roll_est + 128, 8));
      e.pitch = 15'(asr(pitch_est + 128, 8));
      pending.push_back(e);
    endfunction

    function void check_result(logic [31:0] d, logic u);
      tilt_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", d);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d[15:0] !== e.roll || d[30:16] !== e.pitch || d[31] !== 1'b0 || u !== e.first) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp roll %0d pitch %0d first %0b, got roll %0d pitch %0d first %0b",
                   e.roll, e.pitch, e.first, $signed(d[15:0]), $signed(d[30:16]), u);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 0, cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  tilt_scoreboard sb = new();
  int sent;
  bit hold_off;

  complementary_tilt_filter_unit #(.CORDIC_STEPS(CordicSteps)) dut (.*);

  initial forever #5 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Offer one item after a random gap; valid stays high when no gap follows
  task automatic send_sample(logic [79:0] d);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(d);
    sent++;
  endtask

  task automatic write_cfg(int idx, logic [15:0] val);
    cfg_valid_i <= 1; cfg_index_i <= 1'(idx); cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk_i); guard++;
    end
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [79:0] rnd_sample();
    return {rnd_axis(), rnd_axis(), rnd_axis(), rnd_axis(), rnd_axis()};
  endfunction

  // Result side: random stalls plus one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (hold_off) m_axis_tready <= 0;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    @(posedge rst_ni);
    repeat (50) @(posedge clk_i);
    hold_off = 1;
    repeat (2000) @(posedge clk_i);
    hold_off = 0;
  end

  initial begin
    #50ms;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    logic [15:0] weights[5];
    logic [15:0] periods[5];
    weights = '{0, 65535, 58982, 32768, 1};
    periods = '{65535, 1, 10000, 0, 500};
    sb.reset_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: zero vector first, axis extremes, negative-x quadrants
    send_sample('0);
    send_sample({16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000});
    send_sample({16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
    send_sample({16'h0000, 16'h0000, 16'h8000, 16'h0001, 16'h0001});
    send_sample({16'h0000, 16'h0000, 16'h8000, 16'hffff, 16'h0000});
    send_sample({16'h0000, 16'h7fff, 16'hffff, 16'h0000, 16'h0000});
    send_sample({16'h0000, 16'h8000, 16'hffff, 16'h0000, 16'h8000});
    send_sample({16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
    send_sample({16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h7fff});
    send_sample({16'h8000, 16'h8000, 16'h0000, 16'h0001, 16'h8000});

    // Sweep register settings, random samples in each
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_cfg(IdxWeight, weights[ph]);
      write_cfg(IdxPeriod, periods[ph]);
      for (int n = 0; n < 180; n++) send_sample(rnd_sample());
    end

    drain();
    $display("covered %0d samples, %0d results checked over 5 register settings",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches, %0d left", sb.mismatches, sb.pending.size());
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// File: sim.f
design/ctf_pkg.sv
design/complementary_tilt_filter_unit.sv
verif/tb.sv
